FILE: hw/rtl/ifsc_pkg.sv
// Shared types and constants for the IMU frame sync / checksum block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package ifsc_pkg;

  localparam int FRAME_BYTES_DEF = 64;
  localparam int TAG_OFFSET_DEF  = 29;
  localparam int RATE_OFFSET_DEF = 38;

  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int RATE_W   = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h41;
  localparam logic [BYTE_W-1:0] GYRO_TAG_RST      = 8'h43;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 2'd0,
    CFG_HEADER_SECOND = 2'd1,
    CFG_GYRO_TAG      = 2'd2
  } cfg_idx_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_RATE     = 2'd0,
    STATUS_NO_TAG   = 2'd1,
    STATUS_NO_FRAME = 2'd2
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] gyro_tag;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [RATE_W-1:0] rate_bits;
  } result_t;

endpackage

FILE: hw/rtl/ifsc_if.sv
// Valid/ready stream interfaces for the byte input and the result output.
// Depends on ifsc_pkg for field widths and the status type.
`timescale 1ns / 1ps

interface ifsc_in_if;
  import ifsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface ifsc_out_if;
  import ifsc_pkg::*;
  logic              valid;
  logic              ready;
  status_t           status;
  logic [RATE_W-1:0] rate_bits;

  modport source (output valid, output status, output rate_bits, input ready);
  modport sink   (input valid, input status, input rate_bits, output ready);
endinterface

FILE: hw/rtl/ifsc_cfg_regs.sv
// Configuration registers: header bytes and gyro tag, written by index.
// Depends on ifsc_pkg.
`timescale 1ns / 1ps

module ifsc_cfg_regs
  import ifsc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata,
  output cfg_t                 cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HEADER_FIRST:  cfg_nxt.header_first  = cfg_wdata;
        CFG_HEADER_SECOND: cfg_nxt.header_second = cfg_wdata;
        CFG_GYRO_TAG:      cfg_nxt.gyro_tag      = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first  <= HEADER_FIRST_RST;
      cfg_r.header_second <= HEADER_SECOND_RST;
      cfg_r.gyro_tag      <= GYRO_TAG_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hw/rtl/ifsc_window.sv
// Sliding window, running sum and per-buffer state; detects the first valid
// frame and the no-frame end of a buffer. Depends on ifsc_pkg.
`timescale 1ns / 1ps

module ifsc_window
  import ifsc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int TAG_OFFSET  = TAG_OFFSET_DEF,
  parameter int RATE_OFFSET = RATE_OFFSET_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [BYTE_W-1:0] rx_byte,
  input  logic              end_of_buffer,
  input  cfg_t              cfg,
  output logic              res_valid,
  output result_t           res
);

  localparam int WIN_LEN = FRAME_BYTES + 1;
  localparam int SEEN_W  = $clog2(WIN_LEN + 1);
  localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WIN_LEN);

  logic [BYTE_W-1:0] win_r     [WIN_LEN];
  logic [BYTE_W-1:0] win_shift [WIN_LEN];
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [SEEN_W-1:0] seen_r, seen_nxt;
  logic              found_r, found_nxt;

  logic [BYTE_W-1:0] tag_byte;
  logic [BYTE_W-1:0] rate_byte [4];
  logic              hit;
  logic              found_any;

  // window after the incoming byte is shifted in; index 0 is the oldest
  always_comb begin
    for (int i = 0; i < WIN_LEN - 1; i++) begin
      win_shift[i] = win_r[i+1];
    end
    win_shift[WIN_LEN-1] = rx_byte;
  end

  // bytes past the end of the window read as zero
  generate
    if (TAG_OFFSET < WIN_LEN) begin : g_tag_in
      assign tag_byte = win_shift[TAG_OFFSET];
    end else begin : g_tag_out
      assign tag_byte = '0;
    end
    for (genvar k = 0; k < 4; k++) begin : g_rate
      if (RATE_OFFSET + k < WIN_LEN) begin : g_in
        assign rate_byte[k] = win_shift[RATE_OFFSET+k];
      end else begin : g_out
        assign rate_byte[k] = '0;
      end
    end
  endgenerate

  always_comb begin
    sum_nxt  = sum_r + win_r[WIN_LEN-1] - win_r[0];
    seen_nxt = (seen_r < SEEN_FULL) ? seen_r + SEEN_W'(1) : seen_r;
    hit = !found_r && (seen_nxt == SEEN_FULL) &&
          (win_shift[0] == cfg.header_first) &&
          (win_shift[1] == cfg.header_second) &&
          (rx_byte == sum_nxt);
    found_any = found_r || hit;
    found_nxt = end_of_buffer ? 1'b0 : found_any;
  end

  always_comb begin
    res_valid     = hit || (end_of_buffer && !found_any);
    res.status    = STATUS_NO_FRAME;
    res.rate_bits = '0;
    if (hit) begin
      if (tag_byte == cfg.gyro_tag) begin
        res.status    = STATUS_RATE;
        res.rate_bits = {rate_byte[0], rate_byte[1], rate_byte[2], rate_byte[3]};
      end else begin
        res.status = STATUS_NO_TAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      sum_r   <= '0;
      seen_r  <= '0;
      found_r <= 1'b0;
    end else if (accept) begin
      win_r   <= win_shift;
      sum_r   <= sum_nxt;
      seen_r  <= end_of_buffer ? '0 : seen_nxt;
      found_r <= found_nxt;
    end
  end

endmodule

FILE: hw/rtl/ifsc_out_reg.sv
// Output register for result words; input ready is taken from its state.
// Depends on ifsc_pkg.
`timescale 1ns / 1ps

module ifsc_out_reg
  import ifsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              res_valid,
  input  result_t           res,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output status_t           out_status,
  output logic [RATE_W-1:0] out_rate_bits
);

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = res_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid     = valid_r;
  assign out_status    = res_r.status;
  assign out_rate_bits = res_r.rate_bits;

endmodule

FILE: hw/rtl/imu_frame_sync_checksum_top.sv
// Top level of the IMU frame sync / checksum block.
// Depends on ifsc_pkg, ifsc_if, ifsc_cfg_regs, ifsc_window, ifsc_out_reg.
//
//   port    direction  word
//   in_ch   sink       rx_byte[7:0], end_of_buffer
//   out_ch  source     status[1:0], rate_bits[31:0]
//   cfg_*   write      cfg_index 0..2, cfg_wdata[7:0]
//
// One byte per cycle while in_ch.ready is high; a result word appears in the
// cycle after the byte that causes it, from a single output register.
// The window sum is updated incrementally, so each byte costs one add/subtract.
// in_ch.ready is low only while a result is held and out_ch.ready is low.
// Synchronous reset clears the window, sum and buffer state; no clearing pass.
`timescale 1ns / 1ps

module imu_frame_sync_checksum_top
  import ifsc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int TAG_OFFSET  = TAG_OFFSET_DEF,
  parameter int RATE_OFFSET = RATE_OFFSET_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  ifsc_in_if.sink              in_ch,
  ifsc_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_wdata
);

  cfg_t    cfg;
  logic    accept;
  logic    in_ready;
  logic    res_valid;
  result_t res;

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  ifsc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  ifsc_window #(
    .FRAME_BYTES (FRAME_BYTES),
    .TAG_OFFSET  (TAG_OFFSET),
    .RATE_OFFSET (RATE_OFFSET)
  ) u_window (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .rx_byte       (in_ch.rx_byte),
    .end_of_buffer (in_ch.end_of_buffer),
    .cfg           (cfg),
    .res_valid     (res_valid),
    .res           (res)
  );

  ifsc_out_reg u_out (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .res_valid     (res_valid),
    .res           (res),
    .in_ready      (in_ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_rate_bits (out_ch.rate_bits)
  );

endmodule
